[hdl/hrhp_pkg.sv]
// Shared types, constants and helper functions of the HTTP request head parser.
// Holds the method token table, the parse phase and result codes, and the stage structs.
// Depends on nothing; every other file of the block but hrhp_if imports it.
`default_nettype none

package hrhp_pkg;

  localparam int unsigned NumMethods = 8;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 16;
  localparam int unsigned AddrCntW   = 8;
  localparam int unsigned MethodW    = 3;

  // Bytes at a lower index than this end the head too early.
  localparam logic [CountW-1:0] ShortHeadLimit = 16'd8;

  localparam logic [ByteW-1:0] CharSpace    = 8'h20;
  localparam logic [ByteW-1:0] CharLf       = 8'h0A;
  localparam logic [ByteW-1:0] CharCr       = 8'h0D;
  localparam logic [ByteW-1:0] CharQuestion = 8'h3F;

  localparam logic [ByteW-1:0]  AddrMaxReset  = 8'd127;
  localparam logic [CountW-1:0] HeadMaxReset  = 16'd4096;

  // Configuration register indexes.
  localparam logic CfgAddrMax = 1'b0;
  localparam logic CfgHeadMax = 1'b1;

  // Method codes that skip the address.
  localparam logic [MethodW-1:0] MethodHead    = 3'd2;
  localparam logic [MethodW-1:0] MethodOptions = 3'd7;

  // Method tokens, first character in the top byte, padded with a filler that is never compared.
  localparam logic [63:0] TokenText [NumMethods] = '{
    "GET ####", "PUT ####", "HEAD ###", "SOURCE #",
    "POST ###", "DELETE #", "PATCH ##", "OPTIONS "
  };

  // Position of the trailing space in each token.
  localparam logic [2:0] TokenLast [NumMethods] = '{
    3'd3, 3'd3, 3'd4, 3'd6, 3'd4, 3'd6, 3'd5, 3'd7
  };

  typedef enum logic [1:0] {
    PH_METHOD  = 2'd0,
    PH_ADDRESS = 2'd1,
    PH_SKIP    = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ADDRESS = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE           = 2'd0,
    ERR_UNKNOWN_METHOD = 2'd1,
    ERR_HEAD_SHORT     = 2'd2,
    ERR_HEAD_LONG      = 2'd3
  } error_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             start_of_request;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0]  address_max_bytes;
    logic [CountW-1:0] max_head_length;
  } cfg_t;

  typedef struct packed {
    logic [NumMethods-1:0] cand;
    logic                  hit;
    logic [MethodW-1:0]    method;
  } match_t;

  typedef struct packed {
    kind_e               kind;
    logic [ByteW-1:0]    address_byte;
    logic [MethodW-1:0]  method;
    logic [AddrCntW-1:0] address_length;
    error_e              error_code;
  } result_t;

  function automatic logic [ByteW-1:0] token_char(input logic [MethodW-1:0] m,
                                                  input logic [2:0] pos);
    logic [63:0] text;
    text = TokenText[m];
    return text[63 - 8 * int'(pos) -: 8];
  endfunction

  // Lowest set candidate bit; zero when none is set.
  function automatic logic [MethodW-1:0] first_method(input logic [NumMethods-1:0] cand);
    logic [MethodW-1:0] m;
    m = '0;
    for (int i = NumMethods - 1; i >= 0; i--) begin
      if (cand[i]) begin
        m = MethodW'(i);
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[hdl/hrhp_if.sv]
// Valid/ready channel interfaces of the HTTP request head parser.
// hrhp_in_if carries request bytes, hrhp_out_if carries result items.
// Self-contained; used by the top level and the testbench.
`default_nettype none

interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_request;

  modport source (output valid, output data_byte, output start_of_request, input ready);
  modport sink   (input valid, input data_byte, input start_of_request, output ready);
endinterface

interface hrhp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] address_byte;
  logic [2:0] method;
  logic [7:0] address_length;
  logic [1:0] error_code;

  modport source (output valid, output kind, output address_byte, output method,
                  output address_length, output error_code, input ready);
  modport sink   (input valid, input kind, input address_byte, input method,
                  input address_length, input error_code, output ready);
endinterface

`default_nettype wire

[hdl/http_request_head_parser_unit.sv]
// Top level of the HTTP request head parser: input register, parse step, result register.
// Also holds the two configuration registers.
// Depends on hrhp_pkg, hrhp_if and hrhp_parse_step.
//
//   Channel   Direction  Payload
//   req_in    in         data_byte[7:0], start_of_request
//   res_out   out        kind[1:0], address_byte[7:0], method[2:0],
//                        address_length[7:0], error_code[1:0]
//   cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i[15:0]
//
// Each byte is held in the input register, and the parse step settles between that
// register and the result register, which captures the result as the byte leaves.
// One byte is taken per cycle unless the result register is stalled.
// The parse step advances only when the result register is empty or being emptied.
// A stalled result register holds its item while the input register takes one more byte.
// Reset clears the parse state and sets both configuration registers to their defaults.
`default_nettype none

module http_request_head_parser_unit
  import hrhp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  hrhp_in_if.sink           req_in,
  hrhp_out_if.source        res_out,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CountW-1:0] cfg_data_i
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  cfg_t    cfg_q;
  logic    advance;
  logic    step_valid;
  result_t step_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address_max_bytes <= AddrMaxReset;
      cfg_q.max_head_length   <= HeadMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAddrMax: cfg_q.address_max_bytes <= cfg_data_i[ByteW-1:0];
        CfgHeadMax: cfg_q.max_head_length   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign advance      = in_valid_q && (!out_valid_q || res_out.ready);
  assign req_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_in.valid && req_in.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_in.valid && req_in.ready) begin
      in_item_q.data_byte        <= req_in.data_byte;
      in_item_q.start_of_request <= req_in.start_of_request;
    end
  end

  hrhp_parse_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .cfg_i       (cfg_q),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && step_valid) begin
      out_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_valid) begin
      out_res_q <= step_res;
    end
  end

  assign res_out.valid          = out_valid_q;
  assign res_out.kind           = out_res_q.kind;
  assign res_out.address_byte   = out_res_q.address_byte;
  assign res_out.method         = out_res_q.method;
  assign res_out.address_length = out_res_q.address_length;
  assign res_out.error_code     = out_res_q.error_code;

endmodule

`default_nettype wire

[hdl/hrhp_method_match.sv]
// Method token matcher: drops candidates whose token disagrees with the current byte.
// Reports a completed token when a candidate's trailing space is matched.
// Depends on hrhp_pkg for the token table and the match struct.
`default_nettype none

module hrhp_method_match
  import hrhp_pkg::*;
(
  input  logic [ByteW-1:0]      data_byte_i,
  input  logic [CountW-1:0]     byte_idx_i,
  input  logic [NumMethods-1:0] cand_i,
  output match_t                match_o
);

  logic       in_range;
  logic [2:0] pos;

  assign in_range = (byte_idx_i[CountW-1:3] == '0);
  assign pos      = byte_idx_i[2:0];

  always_comb begin
    logic keep;
    match_o = '0;
    for (int i = 0; i < NumMethods; i++) begin
      keep = cand_i[i] && in_range && (pos <= TokenLast[i]) &&
             (token_char(MethodW'(i), pos) == data_byte_i);
      match_o.cand[i] = keep;
      if (keep && (pos == TokenLast[i])) begin
        match_o.hit    = 1'b1;
        match_o.method = MethodW'(i);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/hrhp_parse_step.sv]
// Parse state and per-byte step logic of the HTTP request head parser.
// Holds the phase, counters and candidates; produces at most one result per byte.
// Depends on hrhp_pkg and hrhp_method_match.
`default_nettype none

module hrhp_parse_step
  import hrhp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output logic    res_valid_o,
  output result_t res_o
);

  phase_e                phase_q, phase_d;
  logic [CountW-1:0]     byte_cnt_q, byte_cnt_d;
  logic [NumMethods-1:0] cand_q, cand_d;
  logic [AddrCntW-1:0]   addr_cnt_q, addr_cnt_d;
  logic                  prev_break_q, prev_break_d;
  logic [1:0]            lf_run_q, lf_run_d;

  phase_e                phase_s;
  logic [CountW-1:0]     byte_idx;
  logic [NumMethods-1:0] cand_s;
  logic [AddrCntW-1:0]   addr_cnt_s;
  logic                  prev_break_s;
  logic [1:0]            lf_run_s;
  logic [ByteW-1:0]      b;
  match_t                match;

  // A start of request clears the state ahead of this byte.
  always_comb begin
    if (item_i.start_of_request) begin
      phase_s      = PH_METHOD;
      byte_idx     = '0;
      cand_s       = '1;
      addr_cnt_s   = '0;
      prev_break_s = 1'b0;
      lf_run_s     = '0;
    end else begin
      phase_s      = phase_q;
      byte_idx     = byte_cnt_q;
      cand_s       = cand_q;
      addr_cnt_s   = addr_cnt_q;
      prev_break_s = prev_break_q;
      lf_run_s     = lf_run_q;
    end
  end

  assign b = item_i.data_byte;

  hrhp_method_match u_match (
    .data_byte_i (b),
    .byte_idx_i  (byte_idx),
    .cand_i      (cand_s),
    .match_o     (match)
  );

  always_comb begin
    logic              is_break;
    logic              is_delim;
    logic              head_end;
    logic [1:0]        lf_tmp;
    logic [CountW:0]   consumed;

    phase_d      = phase_s;
    byte_cnt_d   = byte_idx;
    cand_d       = cand_s;
    addr_cnt_d   = addr_cnt_s;
    prev_break_d = prev_break_s;
    lf_run_d     = lf_run_s;
    res_valid_o  = 1'b0;
    res_o        = '0;
    head_end     = 1'b0;
    lf_tmp       = '0;

    is_break = (b == CharLf) || (b == CharCr);
    is_delim = is_break || (b == CharSpace) || (b == CharQuestion);
    consumed = {1'b0, byte_idx} + {{CountW{1'b0}}, 1'b1};

    if (phase_s != PH_DONE) begin
      unique case (phase_s)
        PH_METHOD: begin
          cand_d = match.cand;
          if (match.hit) begin
            cand_d = '0;
            cand_d[match.method] = 1'b1;
            phase_d = ((match.method == MethodHead) || (match.method == MethodOptions)) ?
                      PH_SKIP : PH_ADDRESS;
          end else if (match.cand == '0) begin
            phase_d = PH_SKIP;
          end
        end
        PH_ADDRESS: begin
          if (is_delim) begin
            phase_d = PH_SKIP;
          end else if (addr_cnt_s < cfg_i.address_max_bytes) begin
            addr_cnt_d           = addr_cnt_s + 1'b1;
            res_valid_o          = 1'b1;
            res_o.kind           = KIND_ADDRESS;
            res_o.address_byte   = b;
            res_o.method         = first_method(cand_s);
            res_o.address_length = addr_cnt_s + 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (is_break) begin
        lf_tmp = prev_break_s ? lf_run_s : 2'd0;
        if (b == CharLf) begin
          lf_tmp = lf_tmp + 2'd1;
        end
        lf_run_d     = lf_tmp;
        prev_break_d = 1'b1;
        head_end     = (lf_tmp >= 2'd2);
      end else begin
        prev_break_d = 1'b0;
      end

      if (head_end) begin
        phase_d              = PH_DONE;
        res_valid_o          = 1'b1;
        res_o                = '0;
        res_o.address_length = addr_cnt_d;
        if (byte_idx < ShortHeadLimit) begin
          res_o.kind       = KIND_ERROR;
          res_o.error_code = ERR_HEAD_SHORT;
        end else if ((phase_s == PH_METHOD) || (cand_d == '0)) begin
          res_o.kind       = KIND_ERROR;
          res_o.error_code = ERR_UNKNOWN_METHOD;
        end else begin
          res_o.kind   = KIND_DONE;
          res_o.method = first_method(cand_d);
        end
      end else begin
        byte_cnt_d = (byte_idx == '1) ? byte_idx : byte_idx + 1'b1;
        if (consumed >= {1'b0, cfg_i.max_head_length}) begin
          phase_d              = PH_DONE;
          res_valid_o          = 1'b1;
          res_o                = '0;
          res_o.kind           = KIND_ERROR;
          res_o.error_code     = ERR_HEAD_LONG;
          res_o.address_length = addr_cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_METHOD;
      byte_cnt_q   <= '0;
      cand_q       <= '1;
      addr_cnt_q   <= '0;
      prev_break_q <= 1'b0;
      lf_run_q     <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      byte_cnt_q   <= byte_cnt_d;
      cand_q       <= cand_d;
      addr_cnt_q   <= addr_cnt_d;
      prev_break_q <= prev_break_d;
      lf_run_q     <= lf_run_d;
    end
  end

endmodule

`default_nettype wire

[sim/http_request_head_parser_unit_tb.sv]
// Self-checking testbench for http_request_head_parser_unit: request bytes go in through a
// valid/ready driver, and every result item is checked against an in-bench parser model.
// Depends on hrhp_pkg, the channel interfaces in hrhp_if and the parser RTL.
module http_request_head_parser_unit_tb;
  import hrhp_pkg::*;

  localparam int ClkHalf      = 10;
  localparam int ResetCycles  = 6;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 6;
  localparam int ReportLimit  = 10;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_idx = 1'b0;
  logic [CountW-1:0] cfg_data = '0;

  hrhp_in_if  req_if ();
  hrhp_out_if res_if ();

  http_request_head_parser_unit dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_in    (req_if),
    .res_out   (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #(ClkHalf) clk = ~clk;

  string method_tokens [NumMethods] = '{
    "GET ", "PUT ", "HEAD ", "SOURCE ", "POST ", "DELETE ", "PATCH ", "OPTIONS "
  };

  // Parser model state and its copy of the configuration registers.
  phase_e       parse_phase = PH_METHOD;
  logic [15:0]  byte_index = '0;
  logic [7:0]   candidates = 8'hFF;
  logic [7:0]   addr_count = '0;
  logic         last_was_break = 1'b0;
  logic [1:0]   lf_count = '0;
  logic [2:0]   found_method = '0;
  logic [7:0]   cfg_addr_max = AddrMaxReset;
  logic [15:0]  cfg_head_max = HeadMaxReset;

  item_t   pending_bytes [$];
  result_t expected_results [$];
  int      bytes_queued = 0;
  int      bytes_taken = 0;
  int      errors = 0;
  int      idle_pct = 0;
  int      send_gap = 0;
  int      stall_gap = 0;
  int      method_turn = 0;

  task automatic clear_parser();
    parse_phase    = PH_METHOD;
    byte_index     = '0;
    candidates     = 8'hFF;
    addr_count     = '0;
    last_was_break = 1'b0;
    lf_count       = '0;
    found_method   = '0;
  endtask

  task automatic advance_parser(input logic [7:0] b, input logic sor);
    int     idx;
    logic   brk;
    logic   hit;
    logic   head_end;
    logic   emit;
    logic [2:0] hit_m;
    phase_e ph;
    result_t r;
    if (sor) clear_parser();
    if (parse_phase == PH_DONE) return;
    idx      = int'(byte_index);
    brk      = (b == CharLf) || (b == CharCr);
    hit      = 1'b0;
    hit_m    = '0;
    head_end = 1'b0;
    emit     = 1'b0;
    r        = '0;
    if (parse_phase == PH_METHOD) begin
      for (int i = 0; i < NumMethods; i++) begin
        if (candidates[i]) begin
          if (idx < method_tokens[i].len() && 8'(method_tokens[i][idx]) == b) begin
            if (idx + 1 == method_tokens[i].len()) begin
              hit   = 1'b1;
              hit_m = 3'(i);
            end
          end else begin
            candidates[i] = 1'b0;
          end
        end
      end
      if (hit) begin
        candidates   = 8'(1 << hit_m);
        found_method = hit_m;
        parse_phase  = (hit_m == MethodHead || hit_m == MethodOptions) ? PH_SKIP : PH_ADDRESS;
      end else if (candidates == 8'h00) begin
        parse_phase = PH_SKIP;
      end
    end else if (parse_phase == PH_ADDRESS) begin
      if (b == CharSpace || b == CharLf || b == CharCr || b == CharQuestion) begin
        parse_phase = PH_SKIP;
      end else if (addr_count < cfg_addr_max) begin
        addr_count       = addr_count + 8'd1;
        emit             = 1'b1;
        r.kind           = KIND_ADDRESS;
        r.address_byte   = b;
        r.method         = found_method;
        r.address_length = addr_count;
        r.error_code     = ERR_NONE;
      end
    end
    if (brk) begin
      if (!last_was_break) lf_count = '0;
      last_was_break = 1'b1;
      if (b == CharLf) lf_count = lf_count + 2'd1;
      if (lf_count >= 2'd2) head_end = 1'b1;
    end else begin
      last_was_break = 1'b0;
    end
    if (head_end) begin
      ph               = parse_phase;
      parse_phase      = PH_DONE;
      r                = '0;
      r.address_length = addr_count;
      if (idx < int'(ShortHeadLimit)) begin
        r.kind       = KIND_ERROR;
        r.error_code = ERR_HEAD_SHORT;
      end else if (ph == PH_METHOD || candidates == 8'h00) begin
        r.kind       = KIND_ERROR;
        r.error_code = ERR_UNKNOWN_METHOD;
      end else begin
        r.kind       = KIND_DONE;
        r.method     = found_method;
        r.error_code = ERR_NONE;
      end
      expected_results.push_back(r);
      return;
    end
    if (byte_index != 16'hFFFF) byte_index = byte_index + 16'd1;
    if (idx + 1 >= int'(cfg_head_max)) begin
      parse_phase      = PH_DONE;
      r                = '0;
      r.kind           = KIND_ERROR;
      r.address_length = addr_count;
      r.error_code     = ERR_HEAD_LONG;
      expected_results.push_back(r);
      return;
    end
    if (emit) expected_results.push_back(r);
  endtask

  always @(posedge clk) begin : req_driver
    logic  take;
    item_t it;
    if (rst_n) begin
      take = !req_if.valid || req_if.ready;
      if (req_if.valid && req_if.ready) begin
        bytes_taken++;
        advance_parser(req_if.data_byte, req_if.start_of_request);
      end
      if (take) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          send_gap = $urandom_range(1, 12) - 1;
          req_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          it = pending_bytes.pop_front();
          req_if.valid            <= 1'b1;
          req_if.data_byte        <= it.data_byte;
          req_if.start_of_request <= it.start_of_request;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : res_monitor
    result_t got;
    result_t want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        got.kind           = kind_e'(res_if.kind);
        got.address_byte   = res_if.address_byte;
        got.method         = res_if.method;
        got.address_length = res_if.address_length;
        got.error_code     = error_e'(res_if.error_code);
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= ReportLimit)
            $display("Unexpected result item: kind %0d byte %02h method %0d length %0d error %0d",
                     got.kind, got.address_byte, got.method, got.address_length,
                     got.error_code);
        end else begin
          want = expected_results.pop_front();
          if (got.kind != want.kind || got.address_byte != want.address_byte ||
              got.method != want.method || got.address_length != want.address_length ||
              got.error_code != want.error_code) begin
            errors++;
            if (errors <= ReportLimit) begin
              $display("Result mismatch after %0d bytes:", bytes_taken);
              $display("  expected kind %0d byte %02h method %0d length %0d error %0d",
                       want.kind, want.address_byte, want.method, want.address_length,
                       want.error_code);
              $display("  got      kind %0d byte %02h method %0d length %0d error %0d",
                       got.kind, got.address_byte, got.method, got.address_length,
                       got.error_code);
            end
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        res_if.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_gap = $urandom_range(1, 12) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic sor);
    item_t it;
    it.data_byte        = b;
    it.start_of_request = sor;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  task automatic queue_text(input string s, input logic sor_first);
    for (int i = 0; i < s.len(); i++) queue_byte(8'(s[i]), (i == 0) ? sor_first : 1'b0);
  endtask

  task automatic wait_quiet();
    while (bytes_taken != bytes_queued || expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgAddrMax) cfg_addr_max = val[7:0];
    else cfg_head_max = val;
  endtask

  task automatic set_config(input logic [7:0] amax, input logic [15:0] hmax);
    write_reg(CfgAddrMax, {8'($urandom), amax});
    write_reg(CfgHeadMax, hmax);
  endtask

  function automatic logic [7:0] address_char();
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == CharSpace || c == CharLf || c == CharCr || c == CharQuestion);
    if ($urandom_range(15) == 0) c = 8'h00;
    return c;
  endfunction

  task automatic add_request(input int long_pct);
    logic [7:0] body [$];
    int         pick;
    int         m;
    int         n;
    int         j;
    logic [7:0] delims [4];
    delims = '{CharSpace, CharQuestion, CharCr, CharLf};
    pick = $urandom_range(99);
    if (pick < 12) begin
      n = $urandom_range(1, 20);
      repeat (n) begin
        if ($urandom_range(3) == 0) body.push_back($urandom_range(1) ? CharLf : CharCr);
        else body.push_back(8'($urandom));
      end
    end else begin
      if (method_turn < NumMethods) begin
        m = method_turn;
        method_turn++;
      end else begin
        m = $urandom_range(NumMethods - 1);
      end
      for (int i = 0; i < method_tokens[m].len(); i++) body.push_back(8'(method_tokens[m][i]));
      if ($urandom_range(9) == 0) begin
        j = $urandom_range(body.size() - 1);
        body[j] = body[j] ^ 8'(1 << $urandom_range(7));
      end
      if ($urandom_range(99) < long_pct) n = $urandom_range(250, 300);
      else if ($urandom_range(9) == 0) n = $urandom_range(13, 40);
      else n = $urandom_range(0, 8);
      repeat (n) body.push_back(address_char());
      body.push_back(delims[$urandom_range(3)]);
      repeat ($urandom_range(3)) begin
        repeat ($urandom_range(10)) body.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(3) != 0) body.push_back(CharCr);
        body.push_back(CharLf);
      end
      case ($urandom_range(3))
        0: begin body.push_back(CharCr); body.push_back(CharLf);
                 body.push_back(CharCr); body.push_back(CharLf); end
        1: begin body.push_back(CharLf); body.push_back(CharLf); end
        2: begin body.push_back(CharLf); body.push_back(CharCr); body.push_back(CharLf); end
        default: begin body.push_back(CharCr); body.push_back(CharLf); body.push_back(CharCr);
                       body.push_back(CharCr); body.push_back(CharLf); end
      endcase
      if (pick < 22) begin
        n = $urandom_range(1, body.size());
        while (body.size() > n) void'(body.pop_back());
      end else if (pick < 27) begin
        n = $urandom_range(1, 6);
        while (body.size() > n) void'(body.pop_back());
        body.push_back(CharLf);
        body.push_back(CharLf);
      end
      repeat ($urandom_range(2)) body.push_back(8'($urandom));
    end
    foreach (body[i])
      queue_byte(body[i], (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(199) == 0));
  endtask

  task automatic add_traffic(input int n_bytes, input int long_pct);
    int first;
    first = bytes_queued;
    while (bytes_queued - first < n_bytes) add_request(long_pct);
  endtask

  initial begin : watchdog
    int n;
    n = 0;
    while (n < CycleLimit) begin
      @(posedge clk);
      n++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    req_if.valid            = 1'b0;
    req_if.data_byte        = '0;
    req_if.start_of_request = 1'b0;
    res_if.ready            = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Head ending too early, a byte after completion, a full PUT request with zero and
    // high address bytes, then a request whose method matches nothing.
    queue_byte(CharLf, 1'b1);
    queue_byte(CharLf, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_text("PUT /", 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_text(" \n\r\n", 1'b0);
    queue_text("Q1234567\n\n", 1'b1);
    wait_quiet();

    set_config(8'd0, 16'd16);
    idle_pct = 30;
    add_traffic(120, 0);
    wait_quiet();

    set_config(8'd3, 16'd10);
    idle_pct = 20;
    add_traffic(120, 0);
    wait_quiet();

    set_config(8'd255, 16'd65535);
    add_request(100);
    add_traffic(60, 0);
    wait_quiet();

    repeat (2) begin
      set_config(8'($urandom_range(1, 40)), 16'($urandom_range(16, 80)));
      idle_pct = $urandom_range(5, 35);
      add_traffic(100, 0);
      wait_quiet();
    end

    set_config(AddrMaxReset, HeadMaxReset);
    idle_pct = 10;
    add_traffic(80, 2);
    wait_quiet();

    set_config(8'($urandom_range(0, 255)), 16'($urandom_range(16, 200)));
    idle_pct = 0;
    add_traffic(100, 0);
    wait_quiet();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
